// File: sv/sui_pkg.sv
// shared types and constants of the set union / intersection / difference core
package sui_pkg;

   // default storage sizes
   localparam int SET_DEPTH_DEF   = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   // fixed field widths
   localparam int ELEM_W = 32;
   localparam int OPC_W  = 2;
   localparam int MODE_W = 2;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // command queue between front and engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // operation mode codes
   localparam logic [MODE_W-1:0] MODE_UNION = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ISECT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIFF  = 2'd2;

   // register index of the mode register
   localparam logic REG_MODE = 1'b0;

   // command codes
   typedef enum logic [OPC_W-1:0] {
      OPC_LOAD_A = 2'd0,
      OPC_LOAD_B = 2'd1,
      OPC_RUN    = 2'd2,
      OPC_CLEAR  = 2'd3
   } opcode_type;

   // head of the command queue as seen by the engine
   typedef struct packed {
      logic       valid;
      opcode_type kind;
   } cmd_ctl_type;

endpackage

// File: sv/sui_front.sv
// front end: accepts items, classifies them and queues commands for the engine
module sui_front #(
   parameter int VALUE_WIDTH = sui_pkg::VALUE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sui_pkg::OPC_W-1:0]         req_opcode,
   input  logic signed [sui_pkg::ELEM_W-1:0] req_element_value,
   output sui_pkg::cmd_ctl_type              cmd_ctl,
   output logic [VALUE_WIDTH-1:0]            cmd_value,
   input  logic                              cmd_pop
);
   import sui_pkg::*;

   opcode_type              in_kind;
   logic [63:0]             in_ext;
   logic [VALUE_WIDTH-1:0]  in_value;
   logic                    push;

   opcode_type              q_kind_ff [QUEUE_DEPTH];
   logic [VALUE_WIDTH-1:0]  q_val_ff  [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   // classify the item and keep the element at the stored width
   always_comb begin
      in_kind = opcode_type'(req_opcode);
      in_ext  = 64'(req_element_value);
      if (in_kind == OPC_LOAD_A || in_kind == OPC_LOAD_B) begin
         in_value = in_ext[VALUE_WIDTH-1:0];
      end else begin
         in_value = '0;
      end
   end

   // queue handshake
   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         q_kind_ff[wr_ptr_ff] <= in_kind;
         q_val_ff[wr_ptr_ff]  <= in_value;
      end
   end

   // head of queue
   assign cmd_ctl.valid = (count_ff != '0);
   assign cmd_ctl.kind  = q_kind_ff[rd_ptr_ff];
   assign cmd_value     = q_val_ff[rd_ptr_ff];

endmodule

// File: sv/sui_engine.sv
// back end: set stores, scan sequencer and result output register
module sui_engine #(
   parameter int SET_DEPTH   = sui_pkg::SET_DEPTH_DEF,
   parameter int VALUE_WIDTH = sui_pkg::VALUE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sui_pkg::cmd_ctl_type              cmd_ctl,
   input  logic [VALUE_WIDTH-1:0]            cmd_value,
   output logic                              cmd_pop,
   input  logic [sui_pkg::MODE_W-1:0]        op_mode,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [sui_pkg::ELEM_W-1:0] rsp_result_value,
   output logic                              rsp_last_item,
   output logic                              rsp_empty_result,
   output logic                              rsp_overflow_seen
);
   import sui_pkg::*;

   localparam int CNT_W = $clog2(SET_DEPTH + 1);
   localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SET_DEPTH);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_LD_CHK  = 10'b00_0000_0010,
      S_LD_CMP  = 10'b00_0000_0100,
      S_UB_CHK  = 10'b00_0000_1000,
      S_UB_TAKE = 10'b00_0001_0000,
      S_A_CHK   = 10'b00_0010_0000,
      S_B_CHK   = 10'b00_0100_0000,
      S_B_CMP   = 10'b00_1000_0000,
      S_A_TAKE  = 10'b01_0000_0000,
      S_FIN     = 10'b10_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]        cnt_b_ff, cnt_b_in;
   logic                    ovf_ff, ovf_in;
   logic [CNT_W-1:0]        sc_ff, sc_in;
   logic [CNT_W-1:0]        ai_ff, ai_in;
   logic [VALUE_WIDTH-1:0]  key_ff, key_in;
   logic                    tgt_b_ff, tgt_b_in;
   logic                    isect_ff, isect_in;
   logic                    pend_v_ff, pend_v_in;
   logic [VALUE_WIDTH-1:0]  pend_val_ff, pend_val_in;

   logic                    out_v_ff, out_v_in;
   logic [ELEM_W-1:0]       out_val_ff, out_val_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_empty_ff, out_empty_in;
   logic                    out_ovf_ff, out_ovf_in;

   logic [VALUE_WIDTH-1:0]  mem_a [SET_DEPTH];
   logic [VALUE_WIDTH-1:0]  mem_b [SET_DEPTH];
   logic [VALUE_WIDTH-1:0]  a_rd_ff, b_rd_ff;
   logic [IDX_W-1:0]        a_raddr, b_raddr, w_addr;
   logic                    wa_en, wb_en;

   logic                    out_free, can_take;
   logic                    push, push_last, push_empty;
   logic [VALUE_WIDTH-1:0]  push_val;
   logic [63:0]             push_ext;
   logic [CNT_W-1:0]        cur_cnt;
   logic [VALUE_WIDTH-1:0]  cur_rd;

   // read addresses: inner scan index, outer A index outside load scans
   always_comb begin
      if (state_ff == S_LD_CHK || state_ff == S_LD_CMP) begin
         a_raddr = sc_ff[IDX_W-1:0];
      end else begin
         a_raddr = ai_ff[IDX_W-1:0];
      end
      b_raddr = sc_ff[IDX_W-1:0];
      cur_cnt = tgt_b_ff ? cnt_b_ff : cnt_a_ff;
      cur_rd  = tgt_b_ff ? b_rd_ff : a_rd_ff;
      w_addr  = cur_cnt[IDX_W-1:0];
   end

   // set stores
   always_ff @(posedge clock) begin
      if (wa_en) begin
         mem_a[w_addr] <= key_ff;
      end
      if (wb_en) begin
         mem_b[w_addr] <= key_ff;
      end
      a_rd_ff <= mem_a[a_raddr];
      b_rd_ff <= mem_b[b_raddr];
   end

   assign out_free = !out_v_ff || !rsp_stall;
   assign can_take = !pend_v_ff || out_free;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_a_in    = cnt_a_ff;
      cnt_b_in    = cnt_b_ff;
      ovf_in      = ovf_ff;
      sc_in       = sc_ff;
      ai_in       = ai_ff;
      key_in      = key_ff;
      tgt_b_in    = tgt_b_ff;
      isect_in    = isect_ff;
      pend_v_in   = pend_v_ff;
      pend_val_in = pend_val_ff;
      cmd_pop     = 1'b0;
      wa_en       = 1'b0;
      wb_en       = 1'b0;
      push        = 1'b0;
      push_val    = pend_val_ff;
      push_last   = 1'b0;
      push_empty  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_ctl.valid) begin
               cmd_pop = 1'b1;
               sc_in   = '0;
               ai_in   = '0;
               unique case (cmd_ctl.kind)
                  OPC_LOAD_A: begin
                     key_in   = cmd_value;
                     tgt_b_in = 1'b0;
                     state_in = S_LD_CHK;
                  end
                  OPC_LOAD_B: begin
                     key_in   = cmd_value;
                     tgt_b_in = 1'b1;
                     state_in = S_LD_CHK;
                  end
                  OPC_RUN: begin
                     isect_in  = (op_mode == MODE_ISECT);
                     pend_v_in = 1'b0;
                     if (op_mode == MODE_UNION) begin
                        state_in = S_UB_CHK;
                     end else if (op_mode == MODE_ISECT || op_mode == MODE_DIFF) begin
                        state_in = S_A_CHK;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  OPC_CLEAR: begin
                     cnt_a_in = '0;
                     cnt_b_in = '0;
                  end
                  default: ;
               endcase
            end
         end

         // duplicate scan over the target set, then append or flag overflow
         S_LD_CHK: begin
            if (sc_ff == cur_cnt) begin
               if (cur_cnt == DEPTH_C) begin
                  ovf_in = 1'b1;
               end else if (tgt_b_ff) begin
                  wb_en    = 1'b1;
                  cnt_b_in = cnt_b_ff + 1'b1;
               end else begin
                  wa_en    = 1'b1;
                  cnt_a_in = cnt_a_ff + 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               state_in = S_LD_CMP;
            end
         end
         S_LD_CMP: begin
            if (cur_rd == key_ff) begin
               state_in = S_IDLE;
            end else begin
               sc_in    = sc_ff + 1'b1;
               state_in = S_LD_CHK;
            end
         end

         // union: all of B in load order
         S_UB_CHK: begin
            if (sc_ff == cnt_b_ff) begin
               ai_in    = '0;
               state_in = S_A_CHK;
            end else begin
               state_in = S_UB_TAKE;
            end
         end
         S_UB_TAKE: begin
            if (can_take) begin
               push        = pend_v_ff;
               pend_v_in   = 1'b1;
               pend_val_in = b_rd_ff;
               sc_in       = sc_ff + 1'b1;
               state_in    = S_UB_CHK;
            end
         end

         // outer walk over A, inner search through B
         S_A_CHK: begin
            if (ai_ff == cnt_a_ff) begin
               state_in = S_FIN;
            end else begin
               sc_in    = '0;
               state_in = S_B_CHK;
            end
         end
         S_B_CHK: begin
            if (sc_ff == cnt_b_ff) begin
               if (!isect_ff) begin
                  state_in = S_A_TAKE;
               end else begin
                  ai_in    = ai_ff + 1'b1;
                  state_in = S_A_CHK;
               end
            end else begin
               state_in = S_B_CMP;
            end
         end
         S_B_CMP: begin
            if (b_rd_ff == a_rd_ff) begin
               if (isect_ff) begin
                  state_in = S_A_TAKE;
               end else begin
                  ai_in    = ai_ff + 1'b1;
                  state_in = S_A_CHK;
               end
            end else begin
               sc_in    = sc_ff + 1'b1;
               state_in = S_B_CHK;
            end
         end
         S_A_TAKE: begin
            if (can_take) begin
               push        = pend_v_ff;
               pend_v_in   = 1'b1;
               pend_val_in = a_rd_ff;
               ai_in       = ai_ff + 1'b1;
               state_in    = S_A_CHK;
            end
         end

         // flush the held item as last, or send the empty marker
         S_FIN: begin
            if (out_free) begin
               push       = 1'b1;
               push_last  = 1'b1;
               push_empty = !pend_v_ff;
               push_val   = pend_v_ff ? pend_val_ff : '0;
               pend_v_in  = 1'b0;
               state_in   = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      push_ext     = 64'($signed(push_val));
      out_v_in     = out_v_ff;
      out_val_in   = out_val_ff;
      out_last_in  = out_last_ff;
      out_empty_in = out_empty_ff;
      out_ovf_in   = out_ovf_ff;
      if (push) begin
         out_v_in     = 1'b1;
         out_val_in   = push_ext[ELEM_W-1:0];
         out_last_in  = push_last;
         out_empty_in = push_empty;
         out_ovf_in   = ovf_ff;
      end else if (!rsp_stall) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_a_ff  <= '0;
         cnt_b_ff  <= '0;
         ovf_ff    <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_a_ff  <= cnt_a_in;
         cnt_b_ff  <= cnt_b_in;
         ovf_ff    <= ovf_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      sc_ff        <= sc_in;
      ai_ff        <= ai_in;
      key_ff       <= key_in;
      tgt_b_ff     <= tgt_b_in;
      isect_ff     <= isect_in;
      pend_val_ff  <= pend_val_in;
      out_val_ff   <= out_val_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_result_value  = out_val_ff;
   assign rsp_last_item     = out_last_ff;
   assign rsp_empty_result  = out_empty_ff;
   assign rsp_overflow_seen = out_ovf_ff;

   // set counts stay within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_a_ff <= DEPTH_C && cnt_b_ff <= DEPTH_C)
      else $error("set count beyond store depth");

   // no result item is held back once a run has finished
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_v_ff)
      else $error("held result item left over in idle");

   // an empty result closes its run
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_empty_ff |-> out_last_ff)
      else $error("empty marker not flagged last");

   // overflow is sticky until reset
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag dropped without reset");

endmodule

// File: sv/set_union_intersection_difference_core.sv
// Set union / intersection / difference core: two sets of unique elements, A and B, are loaded
// one item at a time; a run item streams out the union, intersection or difference A minus B
// as selected by the mode register, with the final item marked last and an empty result sent
// as one item marked empty. Every item goes through a two-entry command queue to a sequencer
// whose set stores have one registered read port each. A load of a value into a set does a
// duplicate search, then an append. A union run streams B first; union, intersection and
// difference runs then walk A with an inner search through B, and the fourth mode code sends
// the empty result. A stalled result side can hold the engine. Up to two items are taken
// while the engine is busy.
module set_union_intersection_difference_core #(
   parameter int SET_DEPTH   = sui_pkg::SET_DEPTH_DEF,
   parameter int VALUE_WIDTH = sui_pkg::VALUE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input item channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sui_pkg::OPC_W-1:0]         req_opcode,
   input  logic signed [sui_pkg::ELEM_W-1:0] req_element_value,
   // result item channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [sui_pkg::ELEM_W-1:0] rsp_result_value,
   output logic                              rsp_last_item,
   output logic                              rsp_empty_result,
   output logic                              rsp_overflow_seen,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sui_pkg::ADDR_W-1:0]        paddr,
   input  logic [sui_pkg::DATA_W-1:0]        pwdata,
   output logic [sui_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);
   import sui_pkg::*;

   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic                    reg_wr;
   cmd_ctl_type             cmd_ctl;
   logic [VALUE_WIDTH-1:0]  cmd_value;
   logic                    cmd_pop;

   // mode register
   assign pready = 1'b1;
   assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);

   always_comb begin
      mode_in = mode_ff;
      if (reg_wr) begin
         mode_in = pwdata[MODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UNION;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // register read-back
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_MODE) begin
         prdata = DATA_W'(mode_ff);
      end
   end

   // front end
   sui_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_element_value (req_element_value),
      .cmd_ctl           (cmd_ctl),
      .cmd_value         (cmd_value),
      .cmd_pop           (cmd_pop)
   );

   // engine
   sui_engine #(
      .SET_DEPTH   (SET_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .cmd_ctl           (cmd_ctl),
      .cmd_value         (cmd_value),
      .cmd_pop           (cmd_pop),
      .op_mode           (mode_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_last_item     (rsp_last_item),
      .rsp_empty_result  (rsp_empty_result),
      .rsp_overflow_seen (rsp_overflow_seen)
   );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the set union / intersection / difference core
module tb_top;
   import sui_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int                DEPTH       = SET_DEPTH_DEF;
   localparam int                SETTLE      = 300;

   typedef struct {
      opcode_type  opcode;
      logic [31:0] value;
   } set_cmd_type;

   typedef struct {
      logic [31:0] value;
      logic        last;
      logic        empty;
      logic        ovf;
   } set_result_type;

   // block ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OPC_W-1:0]         req_opcode = OPC_LOAD_A;
   logic signed [ELEM_W-1:0] req_element_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [ELEM_W-1:0] rsp_result_value;
   logic                     rsp_last_item;
   logic                     rsp_empty_result;
   logic                     rsp_overflow_seen;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [DATA_W-1:0]        pwdata = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   // stimulus and expectations
   set_cmd_type    command_q[$];
   set_result_type set_result_q[$];
   set_cmd_type    next_cmd;
   set_result_type exp_res;
   set_result_type new_res;

   // predicted state of the two sets
   logic [31:0]       set_a_mem [0:DEPTH-1];
   logic [31:0]       set_b_mem [0:DEPTH-1];
   int                size_a = 0;
   int                size_b = 0;
   logic              sticky_ovf = 1'b0;
   logic [MODE_W-1:0] cur_mode = MODE_UNION;

   // bookkeeping
   bit item_taken = 1'b0;
   bit idle_en = 1'b1;
   int gap_left = 0;
   int stall_left = 0;
   int errors = 0;
   int items_sent = 0;
   int runs_sent = 0;
   int results_checked = 0;
   int random_items = 0;

   set_union_intersection_difference_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_last_item     (rsp_last_item),
      .rsp_empty_result  (rsp_empty_result),
      .rsp_overflow_seen (rsp_overflow_seen),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("%0t: timeout, %0d results still expected", $time, set_result_q.size());
      $display("== FAIL ==");
      $finish;
   end

   // search one of the predicted sets
   function automatic bit set_holds(bit in_b, logic [31:0] v);
      int i;
      for (i = 0; i < (in_b ? size_b : size_a); i++) begin
         if ((in_b ? set_b_mem[i] : set_a_mem[i]) == v) return 1'b1;
      end
      return 1'b0;
   endfunction

   // whether element i of A belongs to the result of the current mode
   function automatic bit a_selected(int i);
      bit found;
      found = set_holds(1'b1, set_a_mem[i]);
      return (cur_mode == MODE_ISECT) ? found : !found;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_en) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mix of overlapping small values, extremes and full-range values
   function automatic logic [31:0] pick_element();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 32'($signed($urandom_range(0, 16)) - 8);
      if (r == 4) return 32'h8000_0000;
      if (r == 5) return 32'h7fff_ffff;
      return $urandom;
   endfunction

   task automatic queue_result(logic [31:0] v, logic last, logic empty);
      new_res.value = v;
      new_res.last  = last;
      new_res.empty = empty;
      new_res.ovf   = sticky_ovf;
      set_result_q.push_back(new_res);
   endtask

   // append a new element unless present; a full set drops it and flags overflow
   task automatic add_element(bit to_b, logic [31:0] v);
      if (set_holds(to_b, v)) return;
      if ((to_b ? size_b : size_a) >= DEPTH) begin
         sticky_ovf = 1'b1;
      end else if (to_b) begin
         set_b_mem[size_b] = v;
         size_b++;
      end else begin
         set_a_mem[size_a] = v;
         size_a++;
      end
   endtask

   // expected result items of a run in the current mode
   task automatic predict_run();
      int i;
      int total;
      int k;
      total = 0;
      k = 0;
      if (cur_mode == MODE_UNION) total += size_b;
      if (cur_mode != MODE_UNUSED) begin
         for (i = 0; i < size_a; i++) if (a_selected(i)) total++;
      end
      if (total == 0) begin
         queue_result('0, 1'b1, 1'b1);
      end else begin
         if (cur_mode == MODE_UNION) begin
            for (i = 0; i < size_b; i++) begin
               queue_result(set_b_mem[i], k == total - 1, 1'b0);
               k++;
            end
         end
         for (i = 0; i < size_a; i++) begin
            if (a_selected(i)) begin
               queue_result(set_a_mem[i], k == total - 1, 1'b0);
               k++;
            end
         end
      end
   endtask

   task automatic apply_set_command(opcode_type op, logic [31:0] v);
      case (op)
         OPC_LOAD_A: add_element(1'b0, v);
         OPC_LOAD_B: add_element(1'b1, v);
         OPC_RUN: begin
            predict_run();
            runs_sent++;
         end
         default: begin
            size_a = 0;
            size_b = 0;
         end
      endcase
   endtask

   // check result items and predict accepted input items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (set_result_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result item, expected none", $time);
               $display("%0t:   got value %h last %b empty %b ovf %b",
                        $time, rsp_result_value, rsp_last_item, rsp_empty_result,
                        rsp_overflow_seen);
            end else begin
               exp_res = set_result_q.pop_front();
               if (rsp_result_value !== exp_res.value || rsp_last_item !== exp_res.last ||
                   rsp_empty_result !== exp_res.empty || rsp_overflow_seen !== exp_res.ovf) begin
                  errors++;
                  $display("%0t: result mismatch, expected value %h last %b empty %b ovf %b",
                           $time, exp_res.value, exp_res.last, exp_res.empty, exp_res.ovf);
                  $display("%0t:                  got      value %h last %b empty %b ovf %b",
                           $time, rsp_result_value, rsp_last_item, rsp_empty_result,
                           rsp_overflow_seen);
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_set_command(opcode_type'(req_opcode), req_element_value);
            items_sent++;
            item_taken = 1'b1;
         end
      end
   end

   // input item driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || item_taken) begin
         item_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (command_q.size() > 0) begin
            next_cmd = command_q.pop_front();
            req_opcode        <= next_cmd.opcode;
            req_element_value <= next_cmd.value;
            req_valid         <= 1'b1;
            gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side stall
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   task automatic push_cmd(opcode_type op, logic [31:0] v);
      next_cmd.opcode = op;
      next_cmd.value  = v;
      command_q.push_back(next_cmd);
   endtask

   // hold off until every item is sent, every result is back and the engine has settled
   task automatic wait_idle();
      while (command_q.size() != 0 || req_valid || set_result_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // write the mode register and read it back
   task automatic write_mode(logic [MODE_W-1:0] m);
      wait_idle();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= '0;
      pwdata  <= DATA_W'(m);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      cur_mode = m;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== DATA_W'(m)) begin
         errors++;
         $display("%0t: mode readback mismatch, expected %h got %h", $time, DATA_W'(m), prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // one random load sequence ending in one or two runs, with some broken sequences and noise
   task automatic random_phase(int max_size);
      int na;
      int nb;
      int i;
      int n;
      int r;
      n = 0;
      if ($urandom_range(0, 2) == 0) begin
         push_cmd(OPC_CLEAR, $urandom);
         n++;
      end
      na = $urandom_range(0, max_size);
      nb = $urandom_range(0, max_size);
      while (na + nb > 0) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            push_cmd(OPC_RUN, $urandom);
         end else if (r < 5) begin
            push_cmd(OPC_CLEAR, $urandom);
         end else if ((r & 1) && na > 0 || nb == 0) begin
            push_cmd(OPC_LOAD_A, pick_element());
            na--;
         end else begin
            push_cmd(OPC_LOAD_B, pick_element());
            nb--;
         end
         n++;
      end
      for (i = 0; i < $urandom_range(1, 2); i++) begin
         push_cmd(OPC_RUN, $urandom);
         n++;
      end
      random_items += n;
   endtask

   // stimulus
   initial begin
      int phase;
      int i;
      @(negedge clock);
      while (reset) @(negedge clock);

      // directed: empty run in the reset mode, extremes, duplicates, every mode
      push_cmd(OPC_RUN, 32'h1234_5678);
      push_cmd(OPC_LOAD_A, 32'h8000_0000);
      push_cmd(OPC_LOAD_A, 32'h7fff_ffff);
      push_cmd(OPC_LOAD_A, 32'h0000_0000);
      push_cmd(OPC_LOAD_A, 32'hffff_ffff);
      push_cmd(OPC_LOAD_A, 32'h0000_0005);
      push_cmd(OPC_LOAD_A, 32'hffff_ffff);
      push_cmd(OPC_LOAD_B, 32'h0000_0005);
      push_cmd(OPC_LOAD_B, 32'h7fff_ffff);
      push_cmd(OPC_LOAD_B, 32'h5555_5555);
      push_cmd(OPC_LOAD_B, 32'haaaa_aaaa);
      push_cmd(OPC_LOAD_B, 32'h5555_5555);
      push_cmd(OPC_RUN, 32'hffff_ffff);
      write_mode(MODE_ISECT);
      push_cmd(OPC_RUN, '0);
      write_mode(MODE_DIFF);
      push_cmd(OPC_RUN, '0);
      write_mode(MODE_UNUSED);
      push_cmd(OPC_RUN, '0);
      write_mode(MODE_DIFF);
      push_cmd(OPC_CLEAR, 32'hdead_beef);
      push_cmd(OPC_RUN, '0);
      push_cmd(OPC_LOAD_B, 32'h0000_0001);
      push_cmd(OPC_RUN, '0);

      // random phases, mostly small sets, every sixth one drawn up to the full store depth
      phase = 0;
      while (random_items < 45) begin
         write_mode((phase < 4) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 3)));
         idle_en = (phase % 5 != 2);
         random_phase((phase % 6 == 5) ? DEPTH : 6);
         phase++;
      end
      idle_en = 1'b1;

      // full sets, dropped loads, a duplicate while full, then every mode
      write_mode(MODE_UNION);
      push_cmd(OPC_CLEAR, '0);
      for (i = 0; i <= DEPTH; i++) push_cmd(OPC_LOAD_A, 32'(i * 7 - 100));
      push_cmd(OPC_LOAD_A, 32'(-100));
      for (i = 0; i <= DEPTH; i++) push_cmd(OPC_LOAD_B, 32'(i * 14 - 100));
      push_cmd(OPC_RUN, '0);
      write_mode(MODE_ISECT);
      push_cmd(OPC_RUN, '0);
      write_mode(MODE_DIFF);
      push_cmd(OPC_RUN, '0);
      // overflow stays set across a clear
      write_mode(MODE_UNUSED);
      push_cmd(OPC_CLEAR, '0);
      push_cmd(OPC_LOAD_A, $urandom);
      push_cmd(OPC_RUN, '0);

      wait_idle();
      $display("covered %0d input items, %0d runs, %0d result items checked",
               items_sent, runs_sent, results_checked);
      $display("all four modes, empty and full sets, duplicates and sticky overflow exercised");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d errors", errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
